// ----- hw/rtl/rps_pkg.sv -----
// ----------------------------------------------------------------------------
// rps_pkg
// Shared types and constants of the range-partitioned key sorter.
// ----------------------------------------------------------------------------
package rps_pkg;

    localparam int KEY_W        = 64;
    localparam int TAG_W        = 10;
    localparam int OUT_PART_W   = 2;
    localparam int PART_W       = 3;     // enough for up to eight partitions
    localparam int BOUND_REGS   = 4;
    localparam int CFG_IDX_W    = 8;
    localparam int CAPACITY_DEF = 1024;
    localparam int PARTS_DEF    = 4;
    localparam int PARTS_MAX    = 8;

    localparam logic [KEY_W-1:0] BOUND_ZERO_RST  = 64'd2500;
    localparam logic [KEY_W-1:0] BOUND_ONE_RST   = 64'd5000;
    localparam logic [KEY_W-1:0] BOUND_TWO_RST   = 64'd7500;
    localparam logic [KEY_W-1:0] BOUND_THREE_RST = 64'd10000;

    localparam logic [CFG_IDX_W-1:0] REG_BOUND_ZERO  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOUND_ONE   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOUND_TWO   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BOUND_THREE = 8'd3;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SORT_CUR,
        S_SORT_CMP,
        S_SORT_PUT,
        S_FETCH,
        S_DELIVER
    } state_t;

endpackage

// ----- hw/rtl/rps_ram.sv -----
// ----------------------------------------------------------------------------
// rps_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module rps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/range_partitioned_key_sorter_unit.sv -----
// ----------------------------------------------------------------------------
// range_partitioned_key_sorter_unit
// Loads keyed rows into partitions and returns them in sorted order.
// ----------------------------------------------------------------------------
// A load transaction writes the row, with its partition, into a single RAM at
// the next free slot; loads are dropped while the store is full or a batch is
// being read out. The first read transaction of a batch starts an in-place
// insertion sort of that RAM: each row is read, larger neighbours are shifted
// up one slot, and the row is put in its place. Every read after that goes
// through accept, RAM read and output register, the last waiting while the
// output is stalled. Rows come out by partition, then ascending key, equal keys
// in reverse load order; the row that empties the store carries is_last.
module range_partitioned_key_sorter_unit #(
    parameter int CAPACITY   = rps_pkg::CAPACITY_DEF,
    parameter int PARTITIONS = rps_pkg::PARTS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [rps_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rps_pkg::KEY_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          op,
    input  logic [rps_pkg::KEY_W-1:0]     sort_key,
    input  logic [rps_pkg::TAG_W-1:0]     row_tag,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [rps_pkg::KEY_W-1:0]     out_key,
    output logic [rps_pkg::TAG_W-1:0]     out_tag,
    output logic [rps_pkg::OUT_PART_W-1:0] out_part,
    output logic                          is_last
);

    localparam int AW    = $clog2(CAPACITY);
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int KW    = rps_pkg::KEY_W;
    localparam int TW    = rps_pkg::TAG_W;
    localparam int PW    = rps_pkg::PART_W;
    // entry layout, MSB first: partition, key, tag, load slot
    localparam int EW    = PW + KW + TW + AW;
    localparam int IDX_L = 0;
    localparam int TAG_L = AW;
    localparam int KEY_L = AW + TW;
    localparam int PRT_L = AW + TW + KW;

    logic [KW-1:0] bound_reg [rps_pkg::BOUND_REGS];

    rps_pkg::state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] rp_reg, rp_next;
    logic          sorted_reg, sorted_next;
    logic [AW-1:0] i_reg, i_next;
    logic [AW-1:0] j_reg, j_next;
    logic [EW-1:0] cur_reg, cur_next;

    logic          out_valid_reg, out_valid_next;
    logic [EW-1:0] out_ent_reg, out_ent_next;
    logic          last_reg, last_next;

    logic          we;
    logic [AW-1:0] waddr;
    logic [EW-1:0] wdata;
    logic          re;
    logic [AW-1:0] raddr;
    logic [EW-1:0] rdata;

    logic [PW-1:0] pick;
    logic          cur_first;
    logic [CW-1:0] i_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bound_reg[0] <= rps_pkg::BOUND_ZERO_RST;
            bound_reg[1] <= rps_pkg::BOUND_ONE_RST;
            bound_reg[2] <= rps_pkg::BOUND_TWO_RST;
            bound_reg[3] <= rps_pkg::BOUND_THREE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rps_pkg::REG_BOUND_ZERO:  bound_reg[0] <= cfg_data;
                rps_pkg::REG_BOUND_ONE:   bound_reg[1] <= cfg_data;
                rps_pkg::REG_BOUND_TWO:   bound_reg[2] <= cfg_data;
                rps_pkg::REG_BOUND_THREE: bound_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    // First partition whose boundary exceeds the key; later ones saturate.
    always_comb
    begin
        logic found;
        pick  = PW'(PARTITIONS - 1);
        found = 1'b0;
        for (int p = 0; p < PARTITIONS - 1; p++)
        begin
            if (!found)
            begin
                if (p < rps_pkg::BOUND_REGS)
                begin
                    if (sort_key < bound_reg[p])
                    begin
                        pick  = PW'(p);
                        found = 1'b1;
                    end
                end
                else if (sort_key != {KW{1'b1}})
                begin
                    pick  = PW'(p);
                    found = 1'b1;
                end
            end
        end
    end

    // Strict order: partition, key, then later load slot first. The tag
    // plays no part in the order.
    assign cur_first = {cur_reg[EW-1:KEY_L], ~cur_reg[AW-1:IDX_L]}
                     < {rdata[EW-1:KEY_L], ~rdata[AW-1:IDX_L]};

    assign i_inc = CW'(i_reg) + CW'(1);

    rps_ram #(
        .WIDTH (EW),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rps_pkg::S_IDLE;
            count_reg     <= '0;
            rp_reg        <= '0;
            sorted_reg    <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            out_valid_reg <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rp_reg        <= rp_next;
            sorted_reg    <= sorted_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            out_valid_reg <= out_valid_next;
            last_reg      <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg     <= cur_next;
        out_ent_reg <= out_ent_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rp_next        = rp_reg;
        sorted_next    = sorted_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        cur_next       = cur_reg;
        out_valid_next = out_valid_reg;
        out_ent_next   = out_ent_reg;
        last_next      = last_reg;
        we             = 1'b0;
        waddr          = j_reg;
        wdata          = cur_reg;
        re             = 1'b0;
        raddr          = rp_reg[AW-1:0];
        in_ready       = (state_reg == rps_pkg::S_IDLE);

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            rps_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    if (op == rps_pkg::OP_LOAD)
                    begin
                        if (!sorted_reg && count_reg < CW'(CAPACITY))
                        begin
                            we         = 1'b1;
                            waddr      = count_reg[AW-1:0];
                            wdata      = {pick, sort_key, row_tag, count_reg[AW-1:0]};
                            count_next = count_reg + CW'(1);
                        end
                    end
                    else if (count_reg != '0 && rp_reg < count_reg)
                    begin
                        if (!sorted_reg && count_reg > CW'(1))
                        begin
                            re         = 1'b1;
                            raddr      = AW'(1);
                            i_next     = AW'(1);
                            state_next = rps_pkg::S_SORT_CUR;
                        end
                        else
                        begin
                            sorted_next = 1'b1;
                            state_next  = rps_pkg::S_FETCH;
                        end
                    end
                end
            end
            rps_pkg::S_SORT_CUR:
            begin
                cur_next   = rdata;
                j_next     = i_reg;
                re         = 1'b1;
                raddr      = i_reg - AW'(1);
                state_next = rps_pkg::S_SORT_CMP;
            end
            rps_pkg::S_SORT_CMP:
            begin
                if (cur_first)
                begin
                    // Shift the larger neighbour up one slot.
                    we     = 1'b1;
                    waddr  = j_reg;
                    wdata  = rdata;
                    j_next = j_reg - AW'(1);
                    if (j_reg == AW'(1))
                    begin
                        state_next = rps_pkg::S_SORT_PUT;
                    end
                    else
                    begin
                        re    = 1'b1;
                        raddr = j_reg - AW'(2);
                    end
                end
                else
                begin
                    we = 1'b1;
                    if (i_inc == count_reg)
                    begin
                        sorted_next = 1'b1;
                        state_next  = rps_pkg::S_FETCH;
                    end
                    else
                    begin
                        re         = 1'b1;
                        raddr      = i_inc[AW-1:0];
                        i_next     = i_inc[AW-1:0];
                        state_next = rps_pkg::S_SORT_CUR;
                    end
                end
            end
            rps_pkg::S_SORT_PUT:
            begin
                we = 1'b1;
                if (i_inc == count_reg)
                begin
                    sorted_next = 1'b1;
                    state_next  = rps_pkg::S_FETCH;
                end
                else
                begin
                    re         = 1'b1;
                    raddr      = i_inc[AW-1:0];
                    i_next     = i_inc[AW-1:0];
                    state_next = rps_pkg::S_SORT_CUR;
                end
            end
            rps_pkg::S_FETCH:
            begin
                re         = 1'b1;
                state_next = rps_pkg::S_DELIVER;
            end
            rps_pkg::S_DELIVER:
            begin
                // The RAM holds its read data until the output register frees.
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_ent_next   = rdata;
                    state_next     = rps_pkg::S_IDLE;
                    if (rp_reg + CW'(1) >= count_reg)
                    begin
                        last_next   = 1'b1;
                        count_next  = '0;
                        rp_next     = '0;
                        sorted_next = 1'b0;
                    end
                    else
                    begin
                        last_next = 1'b0;
                        rp_next   = rp_reg + CW'(1);
                    end
                end
            end
            default:
            begin
                state_next = rps_pkg::S_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_key   = out_ent_reg[KEY_L +: KW];
    assign out_tag   = out_ent_reg[TAG_L +: TW];
    assign out_part  = out_ent_reg[PRT_L +: rps_pkg::OUT_PART_W];
    assign is_last   = last_reg;

endmodule

// ----- hw/rtl/rps_checker.sv -----
// ----------------------------------------------------------------------------
// rps_checker
// Port-level assertions for the range-partitioned key sorter.
// ----------------------------------------------------------------------------
module rps_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [rps_pkg::KEY_W-1:0]      out_key,
    input logic [rps_pkg::TAG_W-1:0]      out_tag,
    input logic                           is_last
);

    // A stalled result transaction keeps its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_key) && $stable(out_tag)
            && $stable(is_last))
        else $error("result changed while stalled");

    // A new result is only produced while the input side is closed.
    a_rise_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result appeared while input was open");

    // An offered input transaction stays offered until it is taken.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid)
        else $error("input transaction withdrawn before acceptance");

    // The handshake outputs are always driven to known levels.
    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({in_ready, out_valid}))
        else $error("handshake output unknown");

endmodule

bind range_partitioned_key_sorter_unit rps_checker u_rps_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_key   (out_key),
    .out_tag   (out_tag),
    .is_last   (is_last)
);

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the range-partitioned key sorter. Load and read
// transactions are sent through the input channel with random gaps, the
// output channel is stalled at random, and every emitted row is compared with
// the one predicted from the bench's own copy of the store and boundaries.
// ----------------------------------------------------------------------------
module tb_top;
    import rps_pkg::*;

    localparam int CAP       = CAPACITY_DEF;
    localparam int PARTS     = PARTS_DEF;
    localparam int WDOG_MAX  = 600000;
    localparam int SETTLE    = 20;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'd4;

    typedef struct {
        logic [KEY_W-1:0]      key;
        logic [TAG_W-1:0]      tag;
        logic [OUT_PART_W-1:0] part;
        logic                  last;
    } sorted_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [KEY_W-1:0]       cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic                   op = OP_LOAD;
    logic [KEY_W-1:0]       sort_key = '0;
    logic [TAG_W-1:0]       row_tag = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [KEY_W-1:0]       out_key;
    logic [TAG_W-1:0]       out_tag;
    logic [OUT_PART_W-1:0]  out_part;
    logic                   is_last;

    // Bench copy of the block's state.
    logic [KEY_W-1:0]  bound [BOUND_REGS];
    logic [KEY_W-1:0]  key_mem [CAP];
    logic [TAG_W-1:0]  tag_mem [CAP];
    int unsigned       part_mem [CAP];
    int unsigned       sort_order [CAP];
    int unsigned       row_count;
    int unsigned       rd_ptr;
    bit                sorted;

    sorted_row_t       rows_due [$];
    int unsigned       errors = 0;
    int unsigned       n_loads = 0;
    int unsigned       n_reads = 0;
    int unsigned       n_rows_out = 0;
    int unsigned       n_cfg = 0;
    int unsigned       idle_cycles = 0;
    bit                no_gaps = 1'b0;

    range_partitioned_key_sorter_unit u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .op(op), .sort_key(sort_key), .row_tag(row_tag),
        .out_valid(out_valid), .out_ready(out_ready),
        .out_key(out_key), .out_tag(out_tag), .out_part(out_part),
        .is_last(is_last)
    );

    always #5 clk = ~clk;

    function automatic int unsigned part_of(logic [KEY_W-1:0] k);
        for (int i = 0; i + 1 < PARTS; i++)
        begin
            if (k < ((i < BOUND_REGS) ? bound[i] : {KEY_W{1'b1}}))
                return i;
        end
        return PARTS - 1;
    endfunction

    function automatic bit ranks_ahead(int unsigned a, int unsigned b);
        if (part_mem[a] != part_mem[b])
            return part_mem[a] < part_mem[b];
        if (key_mem[a] != key_mem[b])
            return key_mem[a] < key_mem[b];
        // Equal keys leave in reverse load order.
        return a > b;
    endfunction

    function automatic void order_batch();
        int unsigned cur;
        int unsigned j;
        for (int unsigned i = 0; i < row_count; i++)
            sort_order[i] = i;
        for (int unsigned i = 1; i < row_count; i++)
        begin
            cur = sort_order[i];
            j = i;
            while (j > 0 && ranks_ahead(cur, sort_order[j-1]))
            begin
                sort_order[j] = sort_order[j-1];
                j--;
            end
            sort_order[j] = cur;
        end
        sorted = 1'b1;
    endfunction

    function automatic void predict(logic o, logic [KEY_W-1:0] k, logic [TAG_W-1:0] t);
        sorted_row_t r;
        int unsigned slot;
        if (o == OP_LOAD)
        begin
            n_loads++;
            if (sorted || row_count >= CAP)
                return;
            key_mem[row_count] = k;
            tag_mem[row_count] = t;
            part_mem[row_count] = part_of(k);
            row_count++;
            return;
        end
        n_reads++;
        if (row_count == 0)
            return;
        if (!sorted)
            order_batch();
        slot = sort_order[rd_ptr];
        r.key = key_mem[slot];
        r.tag = tag_mem[slot];
        r.part = part_mem[slot][OUT_PART_W-1:0];
        rd_ptr++;
        r.last = (rd_ptr >= row_count);
        if (r.last)
        begin
            row_count = 0;
            rd_ptr = 0;
            sorted = 1'b0;
        end
        rows_due.insert(rows_due.size(), r);
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    task automatic send_item(logic o, logic [KEY_W-1:0] k, logic [TAG_W-1:0] t);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        else
        begin
            @(negedge clk);
        end
        in_valid <= 1'b1;
        op <= o;
        sort_key <= k;
        row_tag <= t;
        do
            @(posedge clk);
        while (!in_ready);
        predict(o, k, t);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [KEY_W-1:0] val);
        @(negedge clk);
        in_valid <= 1'b0;
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx < BOUND_REGS)
            bound[idx] = val;
        n_cfg++;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Waits until every predicted row has come out and the block has settled.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (rows_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic read_out_batch();
        int unsigned pending;
        pending = row_count - rd_ptr;
        repeat (pending)
            send_item(OP_READ, {$urandom, $urandom}, TAG_W'($urandom));
    endtask

    function automatic logic [KEY_W-1:0] rand_key();
        logic [KEY_W-1:0] b;
        case ($urandom_range(0, 3))
            0: return {$urandom, $urandom};
            1: return KEY_W'($urandom_range(0, 12000));
            2: return KEY_W'($urandom_range(0, 7));
            default:
            begin
                b = bound[$urandom_range(0, BOUND_REGS-1)];
                return b + KEY_W'($urandom_range(0, 2)) - KEY_W'(1);
            end
        endcase
    endfunction

    // Directed: reset boundaries, keys on either side of each, the extremes,
    // repeated keys and a read of an empty store.
    task automatic test_reset_boundaries();
        logic [KEY_W-1:0] keys [12];
        keys = '{64'd2499, 64'd0, 64'd2500, 64'd4999, 64'd5000, 64'd7499,
                 64'd7500, 64'd9999, 64'd10000, {KEY_W{1'b1}}, 64'd5000, 64'd5000};
        send_item(OP_READ, '0, '0);
        for (int i = 0; i < 12; i++)
            send_item(OP_LOAD, keys[i], (i == 0) ? 10'h3ff : 10'(i));
        read_out_batch();
        send_item(OP_READ, '0, '0);
        drain();
    endtask

    // Boundary extremes, boundaries out of order, an unused register index
    // and loads arriving once reading has started.
    task automatic test_boundary_settings();
        write_reg(REG_BOUND_ZERO, '0);
        write_reg(REG_BOUND_ONE, '0);
        write_reg(REG_BOUND_TWO, '0);
        write_reg(REG_BOUND_THREE, '0);
        send_item(OP_LOAD, 64'd0, 10'h155);
        send_item(OP_LOAD, {KEY_W{1'b1}}, 10'h2aa);
        read_out_batch();
        drain();
        write_reg(REG_BOUND_ZERO, {KEY_W{1'b1}});
        write_reg(REG_BOUND_ONE, {KEY_W{1'b1}});
        write_reg(REG_BOUND_TWO, {KEY_W{1'b1}});
        write_reg(REG_BOUND_THREE, {KEY_W{1'b1}});
        write_reg(REG_UNUSED, 64'd3);
        send_item(OP_LOAD, {KEY_W{1'b1}}, 10'd1);
        send_item(OP_LOAD, 64'h5555_5555_5555_5555, 10'd2);
        send_item(OP_LOAD, 64'haaaa_aaaa_aaaa_aaaa, 10'd3);
        send_item(OP_READ, '0, '0);
        send_item(OP_LOAD, 64'd7, 10'd4);
        read_out_batch();
        drain();
        write_reg(REG_BOUND_ZERO, 64'd9000);
        write_reg(REG_BOUND_ONE, 64'd100);
        write_reg(REG_BOUND_TWO, 64'd5000);
        for (int i = 0; i < 6; i++)
            send_item(OP_LOAD, 64'd50 * 64'(i * i), 10'(i));
        read_out_batch();
        drain();
    endtask

    task automatic test_random_batches();
        int unsigned sent;
        int unsigned n;
        logic [KEY_W-1:0] b;
        sent = 0;
        while (sent < 750)
        begin
            for (int r = 0; r < BOUND_REGS; r++)
            begin
                b = ($urandom_range(0, 4) == 0) ? {$urandom, $urandom}
                                                : 64'($urandom_range(0, 12000));
                write_reg(r[CFG_IDX_W-1:0], b);
            end
            no_gaps = ($urandom_range(0, 5) == 0);
            n = $urandom_range(1, 30);
            for (int i = 0; i < n; i++)
            begin
                send_item(OP_LOAD, rand_key(), TAG_W'($urandom));
                sent++;
            end
            while (row_count != 0)
            begin
                // Now and then a stray load, ignored while reading is under way.
                if ($urandom_range(0, 9) == 0)
                    send_item(OP_LOAD, rand_key(), TAG_W'($urandom));
                else
                    send_item(OP_READ, {$urandom, $urandom}, TAG_W'($urandom));
                sent++;
            end
            if ($urandom_range(0, 3) == 0)
            begin
                send_item(OP_READ, '0, '0);
                sent++;
            end
            drain();
        end
        no_gaps = 1'b0;
    endtask

    always @(negedge clk)
    begin : sink_stall
        int unsigned hold;
        int unsigned r;
        if (hold > 0)
        begin
            hold--;
        end
        else
        begin
            r = $urandom_range(0, 99);
            out_ready <= (r >= 25);
            if (r < 15)
                hold = $urandom_range(0, 2);
            else if (r < 25)
                hold = $urandom_range(5, 40);
            else
                hold = $urandom_range(0, 20);
        end
    end

    always @(posedge clk)
    begin : row_check
        sorted_row_t want;
        if (rst_n && out_valid && out_ready)
        begin
            n_rows_out++;
            if (rows_due.size() == 0)
            begin
                $display("%0t: unexpected row key=%h tag=%h part=%0d last=%0b",
                         $time, out_key, out_tag, out_part, is_last);
                errors++;
            end
            else
            begin
                want = rows_due.pop_front();
                if (out_key !== want.key)
                begin
                    $display("%0t: out_key expected %h actual %h", $time, want.key, out_key);
                    errors++;
                end
                if (out_tag !== want.tag)
                begin
                    $display("%0t: out_tag expected %h actual %h", $time, want.tag, out_tag);
                    errors++;
                end
                if (out_part !== want.part)
                begin
                    $display("%0t: out_part expected %0d actual %0d",
                             $time, want.part, out_part);
                    errors++;
                end
                if (is_last !== want.last)
                begin
                    $display("%0t: is_last expected %0b actual %0b",
                             $time, want.last, is_last);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX)
        begin
            $display("%0t: no transaction for %0d cycles", $time, WDOG_MAX);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        bound[0] = BOUND_ZERO_RST;
        bound[1] = BOUND_ONE_RST;
        bound[2] = BOUND_TWO_RST;
        bound[3] = BOUND_THREE_RST;
        row_count = 0;
        rd_ptr = 0;
        sorted = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_reset_boundaries();
        test_boundary_settings();
        test_random_batches();
        drain();
        $display("Covered %0d loads and %0d reads, %0d rows checked, %0d register writes.",
                 n_loads, n_reads, n_rows_out, n_cfg);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
